// ----- src/prefix_code_tree_decoder_defines.svh -----
// Assertion macros shared by the prefix code tree decoder modules.
`ifndef PREFIX_CODE_TREE_DECODER_DEFINES_SVH
`define PREFIX_CODE_TREE_DECODER_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define PCTD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define PCTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/pctd_pkg.sv -----
// Types and constants of the prefix code tree decoder.
package pctd_pkg;

    localparam int OP_W       = 2;
    localparam int SYM_W      = 8;
    localparam int CODE_W     = 16;
    localparam int LEN_IN_W   = 5;
    localparam int BYTE_W     = 8;
    localparam int TAIL_W     = 3;
    localparam int CHUNK_BITS = 6;
    localparam int CHUNK_W    = CHUNK_BITS;
    localparam int BCNT_W     = $clog2(CHUNK_BITS + 1);

    localparam logic [BYTE_W-1:0] TEXT_BIAS = 8'd48;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_DECODE = 2'd2;

    typedef struct packed {
        logic             produce;
        logic             finish;
        logic [SYM_W-1:0] symbol;
        logic             error;
        logic             table_full;
    } res_ctl_t;

    typedef struct packed {
        logic room;
        logic staged;
    } res_stat_t;

endpackage

// ----- src/pctd_item_if.sv -----
// Input transaction channel of the prefix code tree decoder.
interface pctd_item_if;

    logic                              valid;
    logic                              ready;
    logic [pctd_pkg::OP_W-1:0]         operation;
    logic [pctd_pkg::SYM_W-1:0]        code_symbol;
    logic [pctd_pkg::CODE_W-1:0]       code_bits;
    logic [pctd_pkg::LEN_IN_W-1:0]     code_length;
    logic [pctd_pkg::BYTE_W-1:0]       data_byte;
    logic                              last_chunk;
    logic [pctd_pkg::TAIL_W-1:0]       tail_bits;

    modport source (
        output valid, operation, code_symbol, code_bits, code_length,
               data_byte, last_chunk, tail_bits,
        input  ready
    );

    modport sink (
        input  valid, operation, code_symbol, code_bits, code_length,
               data_byte, last_chunk, tail_bits,
        output ready
    );

endinterface

// ----- src/pctd_result_if.sv -----
// Result transaction channel of the prefix code tree decoder.
interface pctd_result_if;

    logic                       valid;
    logic                       ready;
    logic [pctd_pkg::SYM_W-1:0] symbol;
    logic                       error;
    logic                       table_full;
    logic                       last;

    modport source (
        output valid, symbol, error, table_full, last,
        input  ready
    );

    modport sink (
        input  valid, symbol, error, table_full, last,
        output ready
    );

endinterface

// ----- src/pctd_result_stage.sv -----
// Result staging: holds one result back until its last flag is known.
`include "prefix_code_tree_decoder_defines.svh"

module pctd_result_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  pctd_pkg::res_ctl_t  ctl,
    output pctd_pkg::res_stat_t stat,
    pctd_result_if.source       result
);

    logic                       have_reg;
    logic                       have_next;
    logic [pctd_pkg::SYM_W-1:0] st_symbol_reg;
    logic                       st_error_reg;
    logic                       st_full_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [pctd_pkg::SYM_W-1:0] out_symbol_reg;
    logic                       out_error_reg;
    logic                       out_full_reg;
    logic                       out_last_reg;
    logic                       out_free;
    logic                       room;
    logic                       push;
    logic                       load;

    assign out_free = !out_valid_reg || result.ready;
    assign room     = !have_reg || out_free;
    assign push     = room && have_reg && (ctl.produce || ctl.finish);
    assign load     = room && ctl.produce;

    assign stat.room   = room;
    assign stat.staged = have_reg;

    always_comb
    begin
        have_next = have_reg;
        if (load)
        begin
            have_next = 1'b1;
        end
        else if (room && ctl.finish)
        begin
            have_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            have_reg      <= have_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            st_symbol_reg <= ctl.symbol;
            st_error_reg  <= ctl.error;
            st_full_reg   <= ctl.table_full;
        end
        if (push)
        begin
            out_symbol_reg <= st_symbol_reg;
            out_error_reg  <= st_error_reg;
            out_full_reg   <= st_full_reg;
            out_last_reg   <= ctl.finish;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.symbol     = out_symbol_reg;
    assign result.error      = out_error_reg;
    assign result.table_full = out_full_reg;
    assign result.last       = out_last_reg;

    `PCTD_ASSERT_NEXT(a_finish_sends_last, ctl.finish && room && have_reg,
        result.valid && result.last, "staged result not sent as last")

endmodule

// ----- src/prefix_code_tree_decoder.sv -----
// Top level of the prefix code tree decoder: code tree build and tree walk over a node memory.
//
// One transaction is handled at a time. Adding a code of length L (capped at MAX_CODE_LEN)
// takes one node step per code bit, plus the final symbol write; an add that runs out of
// nodes ends at the failing step. Decoding a data byte of N bits (six, or tail_bits on a
// last chunk when it lies between one and five) takes at most one node memory read per bit,
// a separate step to emit each leaf symbol, plus the entry and end steps. The single port
// node memory has a registered read port, and a stalled result channel holds the walk.
// The root node lives in flip-flops, so no clearing pass follows reset.
`include "prefix_code_tree_decoder_defines.svh"

module prefix_code_tree_decoder #(
    parameter int MAX_NODES    = 512,
    parameter int MAX_CODE_LEN = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    pctd_item_if.sink     item,
    pctd_result_if.source result
);

    localparam int IDX_W   = $clog2(MAX_NODES);
    localparam int NF_W    = $clog2(MAX_NODES + 1);
    localparam int SYM_W   = pctd_pkg::SYM_W;
    localparam int ENTRY_W = 2 * IDX_W + SYM_W;
    localparam int L_LSB   = IDX_W + SYM_W;
    localparam int R_LSB   = SYM_W;
    localparam int SH_W    = MAX_CODE_LEN;
    localparam int LEN_W   = $clog2(MAX_CODE_LEN + 1);
    localparam int WIDE_W  = SH_W + pctd_pkg::CODE_W;
    localparam int CW      = pctd_pkg::CHUNK_W;
    localparam int BW      = pctd_pkg::BCNT_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_ADD  = 3'b010,
        ST_DEC  = 3'b100
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    logic [NF_W-1:0]           next_free_reg;
    logic [NF_W-1:0]           next_free_next;
    logic [IDX_W-1:0]          walk_idx_reg;
    logic [IDX_W-1:0]          walk_idx_next;
    logic                      overflow_reg;
    logic                      overflow_next;
    logic [IDX_W-1:0]          root_left_reg;
    logic [IDX_W-1:0]          root_left_next;
    logic [IDX_W-1:0]          root_right_reg;
    logic [IDX_W-1:0]          root_right_next;
    logic [IDX_W-1:0]          head_idx_reg;
    logic [IDX_W-1:0]          head_idx_next;
    logic                      from_mem_reg;
    logic                      from_mem_next;
    logic [LEN_W-1:0]          rem_reg;
    logic [LEN_W-1:0]          rem_next;
    logic [BW-1:0]             bits_left_reg;
    logic [BW-1:0]             bits_left_next;
    logic [SYM_W-1:0]          sym_reg;
    logic [SYM_W-1:0]          sym_next;
    logic [SH_W-1:0]           sh_reg;
    logic [SH_W-1:0]           sh_next;
    logic [CW-1:0]             chunk_reg;
    logic [CW-1:0]             chunk_next;
    logic                      lastc_reg;
    logic                      lastc_next;

    logic [ENTRY_W-1:0]        node_mem [MAX_NODES];
    logic [ENTRY_W-1:0]        rd_data_reg;
    logic                      mem_rd_en;
    logic [IDX_W-1:0]          mem_rd_addr;
    logic                      mem_wr_en;
    logic [IDX_W-1:0]          mem_wr_addr;
    logic [ENTRY_W-1:0]        mem_wr_data;

    logic [IDX_W-1:0]          cur_left;
    logic [IDX_W-1:0]          cur_right;
    logic [SYM_W-1:0]          cur_sym;
    logic                      cur_leaf;
    logic                      add_bit;
    logic [IDX_W-1:0]          slot;
    logic [IDX_W-1:0]          new_left;
    logic [IDX_W-1:0]          new_right;
    logic [IDX_W-1:0]          nf_idx;
    logic                      dec_bit;
    logic [IDX_W-1:0]          child;
    logic                      accept;
    logic [LEN_W-1:0]          len_eff;
    logic [WIDE_W-1:0]         code_wide;
    logic [BW-1:0]             nbits;

    pctd_pkg::res_ctl_t        res_ctl;
    pctd_pkg::res_stat_t       res_stat;

    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;

    assign cur_left  = from_mem_reg ? rd_data_reg[L_LSB +: IDX_W]
                     : ((head_idx_reg == '0) ? root_left_reg : '0);
    assign cur_right = from_mem_reg ? rd_data_reg[R_LSB +: IDX_W]
                     : ((head_idx_reg == '0) ? root_right_reg : '0);
    assign cur_sym   = from_mem_reg ? rd_data_reg[SYM_W-1:0] : '0;
    assign cur_leaf  = (cur_left == '0) && (cur_right == '0);

    assign nf_idx    = next_free_reg[IDX_W-1:0];
    assign add_bit   = sh_reg[SH_W-1];
    assign slot      = add_bit ? cur_right : cur_left;
    assign new_left  = add_bit ? cur_left : nf_idx;
    assign new_right = add_bit ? nf_idx : cur_right;
    assign dec_bit   = chunk_reg[CW-1];
    assign child     = dec_bit ? cur_right : cur_left;

    assign len_eff   = (32'(item.code_length) > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN)
                     : LEN_W'(item.code_length);
    assign code_wide = WIDE_W'(item.code_bits) << (LEN_W'(SH_W) - len_eff);
    assign nbits     = (item.last_chunk && (item.tail_bits != '0)
                        && (32'(item.tail_bits) < pctd_pkg::CHUNK_BITS))
                     ? BW'(item.tail_bits) : BW'(pctd_pkg::CHUNK_BITS);

    always_comb
    begin
        state_next      = state_reg;
        next_free_next  = next_free_reg;
        walk_idx_next   = walk_idx_reg;
        overflow_next   = overflow_reg;
        root_left_next  = root_left_reg;
        root_right_next = root_right_reg;
        head_idx_next   = head_idx_reg;
        from_mem_next   = from_mem_reg;
        rem_next        = rem_reg;
        bits_left_next  = bits_left_reg;
        sym_next        = sym_reg;
        sh_next         = sh_reg;
        chunk_next      = chunk_reg;
        lastc_next      = lastc_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = '0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = head_idx_reg;
        mem_wr_data     = {cur_left, cur_right, cur_sym};
        res_ctl         = '0;
        res_ctl.table_full = overflow_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.operation)
                        pctd_pkg::OP_CLEAR:
                        begin
                            root_left_next  = '0;
                            root_right_next = '0;
                            next_free_next  = NF_W'(1);
                            walk_idx_next   = '0;
                            overflow_next   = 1'b0;
                        end
                        pctd_pkg::OP_ADD:
                        begin
                            sym_next      = item.code_symbol;
                            sh_next       = code_wide[SH_W-1:0];
                            rem_next      = len_eff;
                            head_idx_next = '0;
                            from_mem_next = 1'b0;
                            state_next    = ST_ADD;
                        end
                        pctd_pkg::OP_DECODE:
                        begin
                            chunk_next     = CW'(item.data_byte - pctd_pkg::TEXT_BIAS);
                            bits_left_next = nbits;
                            lastc_next     = item.last_chunk;
                            head_idx_next  = '0;
                            from_mem_next  = (walk_idx_reg != '0);
                            mem_rd_en      = (walk_idx_reg != '0);
                            mem_rd_addr    = walk_idx_reg;
                            state_next     = ST_DEC;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_ADD:
            begin
                if (rem_reg == '0)
                begin
                    mem_wr_en   = (head_idx_reg != '0);
                    mem_wr_data = {cur_left, cur_right, sym_reg};
                    state_next  = ST_IDLE;
                end
                else if (slot == '0)
                begin
                    if (next_free_reg >= NF_W'(MAX_NODES))
                    begin
                        overflow_next = 1'b1;
                        mem_wr_en     = (head_idx_reg != '0);
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        if (head_idx_reg == '0)
                        begin
                            root_left_next  = new_left;
                            root_right_next = new_right;
                        end
                        else
                        begin
                            mem_wr_en   = 1'b1;
                            mem_wr_data = {new_left, new_right, cur_sym};
                        end
                        head_idx_next  = nf_idx;
                        from_mem_next  = 1'b0;
                        next_free_next = next_free_reg + NF_W'(1);
                        rem_next       = rem_reg - LEN_W'(1);
                        sh_next        = sh_reg << 1;
                    end
                end
                else
                begin
                    mem_rd_en     = 1'b1;
                    mem_rd_addr   = slot;
                    head_idx_next = slot;
                    from_mem_next = 1'b1;
                    rem_next      = rem_reg - LEN_W'(1);
                    sh_next       = sh_reg << 1;
                end
            end

            ST_DEC:
            begin
                if (from_mem_reg && cur_leaf)
                begin
                    res_ctl.produce = 1'b1;
                    res_ctl.symbol  = cur_sym;
                    if (res_stat.room)
                    begin
                        walk_idx_next = '0;
                        from_mem_next = 1'b0;
                    end
                end
                else if (bits_left_reg != '0)
                begin
                    if (child == '0)
                    begin
                        res_ctl.produce = 1'b1;
                        res_ctl.error   = 1'b1;
                        if (res_stat.room)
                        begin
                            walk_idx_next  = '0;
                            from_mem_next  = 1'b0;
                            bits_left_next = bits_left_reg - BW'(1);
                            chunk_next     = chunk_reg << 1;
                        end
                    end
                    else
                    begin
                        mem_rd_en      = 1'b1;
                        mem_rd_addr    = child;
                        walk_idx_next  = child;
                        from_mem_next  = 1'b1;
                        bits_left_next = bits_left_reg - BW'(1);
                        chunk_next     = chunk_reg << 1;
                    end
                end
                else
                begin
                    res_ctl.finish = 1'b1;
                    if (res_stat.room)
                    begin
                        if (lastc_reg)
                        begin
                            walk_idx_next = '0;
                        end
                        from_mem_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            next_free_reg  <= NF_W'(1);
            walk_idx_reg   <= '0;
            overflow_reg   <= 1'b0;
            root_left_reg  <= '0;
            root_right_reg <= '0;
            head_idx_reg   <= '0;
            from_mem_reg   <= 1'b0;
            rem_reg        <= '0;
            bits_left_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            next_free_reg  <= next_free_next;
            walk_idx_reg   <= walk_idx_next;
            overflow_reg   <= overflow_next;
            root_left_reg  <= root_left_next;
            root_right_reg <= root_right_next;
            head_idx_reg   <= head_idx_next;
            from_mem_reg   <= from_mem_next;
            rem_reg        <= rem_next;
            bits_left_reg  <= bits_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg   <= sym_next;
        sh_reg    <= sh_next;
        chunk_reg <= chunk_next;
        lastc_reg <= lastc_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            node_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rd_data_reg <= node_mem[mem_rd_addr];
        end
    end

    pctd_result_stage u_result_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (res_ctl),
        .stat   (res_stat),
        .result (result)
    );

    `PCTD_ASSERT_IMPLY(a_no_rd_wr_overlap, mem_rd_en, !mem_wr_en,
        "node memory read and write in the same cycle")
    `PCTD_ASSERT_IMPLY(a_free_in_range, 1'b1,
        (next_free_reg != '0) && (next_free_reg <= NF_W'(MAX_NODES)),
        "next free node out of range")
    `PCTD_ASSERT_IMPLY(a_walk_allocated, 1'b1, NF_W'(walk_idx_reg) < next_free_reg,
        "walk node not allocated")
    `PCTD_ASSERT_IMPLY(a_idle_nothing_staged, state_reg == ST_IDLE, !res_stat.staged,
        "result left staged while idle")

endmodule
